/* hdl/aabb_frustum_cull_macros.svh */
// Assertion macros for the checker file of the frustum culling block.
// No dependencies; include by bare file name.
`ifndef AABB_FRUSTUM_CULL_MACROS_SVH
`define AABB_FRUSTUM_CULL_MACROS_SVH

// Property checked on every clock edge while reset is released
`define AFC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("afc assertion failed");

// Property checked on every clock edge, reset included
`define AFC_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("afc assertion failed");

`endif

/* hdl/afc_pkg.sv */
// Shared types and constants for the frustum culling block.
// No dependencies; imported by afc_cell, aabb_frustum_cull, afc_checker and the testbench.
package afc_pkg;

  localparam int PLANE_COUNT_DEF = 6;
  localparam int FRAC_BITS_DEF   = 16;

  localparam int COORD_W = 32;
  localparam int PROD_W  = 2 * COORD_W;
  // three products plus the scaled offset, with headroom for the sign
  localparam int SUM_W   = PROD_W + 3;
  localparam int SLOT_W  = 3;
  localparam int CODE_W  = 3;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_BOX  = 1'b1
  } action_t;

  // box corners travelling down the cell chain
  typedef struct packed {
    logic [COORD_W-1:0] min_x;
    logic [COORD_W-1:0] min_y;
    logic [COORD_W-1:0] min_z;
    logic [COORD_W-1:0] max_x;
    logic [COORD_W-1:0] max_y;
    logic [COORD_W-1:0] max_z;
  } box_t;

  // per-box status handed from cell to cell
  typedef struct packed {
    logic              valid;
    logic              rejected;
    logic [CODE_W-1:0] code;
  } tok_t;

endpackage

/* hdl/afc_cell.sv */
// One plane cell of the culling chain: holds one plane and tests a passing box.
// Depends on afc_pkg.
module afc_cell
  import afc_pkg::*;
#(
  parameter int IDX       = 0,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load_en,
  input  logic [SLOT_W-1:0]  load_slot,
  input  logic [COORD_W-1:0] load_nx,
  input  logic [COORD_W-1:0] load_ny,
  input  logic [COORD_W-1:0] load_nz,
  input  logic [COORD_W-1:0] load_d,
  input  tok_t               in_tok,
  input  box_t               in_box,
  output tok_t               out_tok,
  output box_t               out_box,
  output logic               live
);

  logic signed [COORD_W-1:0] nx_r, ny_r, nz_r, d_r;
  logic                      wr_en;

  logic signed [COORD_W-1:0] px, py, pz;
  logic signed [PROD_W-1:0]  prod_x, prod_y, prod_z;
  logic signed [PROD_W-1:0]  prod_x_r, prod_y_r, prod_z_r;
  tok_t                      s1_tok_r;
  box_t                      s1_box_r;

  logic signed [SUM_W-1:0]   sum;
  logic                      below;
  tok_t                      s2_tok_r, s2_tok_nxt;
  box_t                      s2_box_r;

  // plane write: a slot beyond the chain matches no cell
  assign wr_en = load_en && ({{(32-SLOT_W){1'b0}}, load_slot} == 32'(IDX));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nx_r <= '0;
      ny_r <= '0;
      nz_r <= '0;
      d_r  <= '0;
    end else if (wr_en) begin
      nx_r <= load_nx;
      ny_r <= load_ny;
      nz_r <= load_nz;
      d_r  <= load_d;
    end
  end

  // positive vertex: max corner where the normal component is non-negative
  assign px = nx_r[COORD_W-1] ? $signed(in_box.min_x) : $signed(in_box.max_x);
  assign py = ny_r[COORD_W-1] ? $signed(in_box.min_y) : $signed(in_box.max_y);
  assign pz = nz_r[COORD_W-1] ? $signed(in_box.min_z) : $signed(in_box.max_z);

  assign prod_x = nx_r * px;
  assign prod_y = ny_r * py;
  assign prod_z = nz_r * pz;

  // stage 1: registered products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_tok_r.valid <= 1'b0;
    end else begin
      s1_tok_r.valid <= in_tok.valid;
    end
    s1_tok_r.rejected <= in_tok.rejected;
    s1_tok_r.code     <= in_tok.code;
    s1_box_r          <= in_box;
    prod_x_r          <= prod_x;
    prod_y_r          <= prod_y;
    prod_z_r          <= prod_z;
  end

  // stage 2: exact n.p + d * 2^FRAC_BITS, only the sign matters
  assign sum = SUM_W'(prod_x_r) + SUM_W'(prod_y_r) + SUM_W'(prod_z_r)
             + (SUM_W'(d_r) <<< FRAC_BITS);
  assign below = sum[SUM_W-1];

  // first rejecting plane wins
  always_comb begin
    s2_tok_nxt.valid    = s1_tok_r.valid;
    s2_tok_nxt.rejected = s1_tok_r.rejected | below;
    s2_tok_nxt.code     = s1_tok_r.rejected ? s1_tok_r.code : CODE_W'(IDX);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_tok_r.valid <= 1'b0;
    end else begin
      s2_tok_r.valid <= s2_tok_nxt.valid;
    end
    s2_tok_r.rejected <= s2_tok_nxt.rejected;
    s2_tok_r.code     <= s2_tok_nxt.code;
    s2_box_r          <= s1_box_r;
  end

  assign out_tok = s2_tok_r;
  assign out_box = s2_box_r;
  assign live    = s1_tok_r.valid | s2_tok_r.valid;

endmodule

/* hdl/aabb_frustum_cull.sv */
// Axis-aligned box versus frustum culling, top level: a chain of plane cells.
// Depends on afc_pkg and afc_cell.
//
// Usage:
//   An item is taken at a rising edge with start high and busy low. in_action
//   selects a plane load (writes plane in_plane_slot, slot beyond the last
//   plane is dropped) or a box test (in_min_* / in_max_* corners).
//   Each item gives one result, shown for one cycle with out_valid high.
//   Loads answer out_visible = 0, out_reject_plane = PLANE_COUNT.
//   Box tests answer out_visible and the first rejecting plane, or
//   PLANE_COUNT when none rejects (code kept to 3 bits).
// Timing:
//   A box walks the cell chain; each plane cell registers the products, then
//   the sum and sign, and a result register follows the last cell. Boxes enter
//   back to back, one per cycle.
//   A load answers on the next cycle. busy is raised only against a load while
//   boxes are still in the chain, so a load waits until the chain is empty.
// Reset:
//   Synchronous, active low; all planes return to zero and the chain empties.
//   The receiver cannot stall; results are never held back.
module aabb_frustum_cull
  import afc_pkg::*;
#(
  parameter int PLANE_COUNT = PLANE_COUNT_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [0:0]         in_action,
  input  logic [SLOT_W-1:0]  in_plane_slot,
  input  logic [COORD_W-1:0] in_normal_x,
  input  logic [COORD_W-1:0] in_normal_y,
  input  logic [COORD_W-1:0] in_normal_z,
  input  logic [COORD_W-1:0] in_plane_offset,
  input  logic [COORD_W-1:0] in_min_x,
  input  logic [COORD_W-1:0] in_min_y,
  input  logic [COORD_W-1:0] in_min_z,
  input  logic [COORD_W-1:0] in_max_x,
  input  logic [COORD_W-1:0] in_max_y,
  input  logic [COORD_W-1:0] in_max_z,
  output logic               out_valid,
  output logic               out_visible,
  output logic [CODE_W-1:0]  out_reject_plane
);

  localparam logic [CODE_W-1:0] NONE_CODE = CODE_W'(PLANE_COUNT);

  tok_t                   tok   [PLANE_COUNT+1];
  box_t                   box   [PLANE_COUNT+1];
  logic [PLANE_COUNT-1:0] live;
  logic                   chain_busy;
  logic                   xfer;
  logic                   load_xfer;
  logic                   box_xfer;

  logic                   out_valid_r,   out_valid_nxt;
  logic                   out_visible_r, out_visible_nxt;
  logic [CODE_W-1:0]      out_reject_r,  out_reject_nxt;

  // loads wait until no box is left in the chain
  assign chain_busy = |live;
  assign busy       = chain_busy && (in_action == ACT_LOAD);
  assign xfer       = start && !busy;
  assign load_xfer  = xfer && (in_action == ACT_LOAD);
  assign box_xfer   = xfer && (in_action == ACT_BOX);

  // head of the chain
  assign tok[0].valid    = box_xfer;
  assign tok[0].rejected = 1'b0;
  assign tok[0].code     = NONE_CODE;
  assign box[0] = '{min_x: in_min_x, min_y: in_min_y, min_z: in_min_z,
                    max_x: in_max_x, max_y: in_max_y, max_z: in_max_z};

  for (genvar i = 0; i < PLANE_COUNT; i++) begin : g_cell
    afc_cell #(
      .IDX       (i),
      .FRAC_BITS (FRAC_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .load_en   (load_xfer),
      .load_slot (in_plane_slot),
      .load_nx   (in_normal_x),
      .load_ny   (in_normal_y),
      .load_nz   (in_normal_z),
      .load_d    (in_plane_offset),
      .in_tok    (tok[i]),
      .in_box    (box[i]),
      .out_tok   (tok[i+1]),
      .out_box   (box[i+1]),
      .live      (live[i])
    );
  end

  // result register: chain tail or load answer, never both in one cycle
  always_comb begin
    out_valid_nxt   = 1'b0;
    out_visible_nxt = 1'b0;
    out_reject_nxt  = NONE_CODE;
    if (tok[PLANE_COUNT].valid) begin
      out_valid_nxt   = 1'b1;
      out_visible_nxt = !tok[PLANE_COUNT].rejected;
      out_reject_nxt  = tok[PLANE_COUNT].rejected ? tok[PLANE_COUNT].code : NONE_CODE;
    end else if (load_xfer) begin
      out_valid_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_visible_r <= out_visible_nxt;
    out_reject_r  <= out_reject_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_visible      = out_visible_r;
  assign out_reject_plane = out_reject_r;

endmodule

/* hdl/afc_checker.sv */
// Port-level assertions for aabb_frustum_cull, bound to the top level.
// Depends on afc_pkg and aabb_frustum_cull_macros.svh.
`include "aabb_frustum_cull_macros.svh"

module afc_checker
  import afc_pkg::*;
#(
  parameter int PLANE_COUNT = PLANE_COUNT_DEF
) (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic [0:0]        in_action,
  input logic              out_valid,
  input logic              out_visible,
  input logic [CODE_W-1:0] out_reject_plane
);

  localparam logic [CODE_W-1:0] NONE_CODE = CODE_W'(PLANE_COUNT);

  logic load_xfer;
  logic load_answer;

  assign load_xfer   = start && !busy && (in_action == ACT_LOAD);
  assign load_answer = out_valid && !out_visible && (out_reject_plane == NONE_CODE);

  // a load transfer answers on the next cycle as a load
  `AFC_ASSERT(a_load_answer, clk, rst_n, load_xfer |=> load_answer)

  // a visible box carries the no-rejection code
  `AFC_ASSERT(a_visible_code, clk, rst_n, (out_valid && out_visible) |-> (out_reject_plane == NONE_CODE))

  // busy only holds off a load
  `AFC_ASSERT(a_busy_load_only, clk, rst_n, busy |-> (in_action == ACT_LOAD))

  // reset leaves no result strobe behind
  `AFC_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_valid)

endmodule

bind aabb_frustum_cull afc_checker #(.PLANE_COUNT(PLANE_COUNT)) u_afc_checker (.*);

/* verif/tb_aabb_frustum_cull.sv */
// Testbench for aabb_frustum_cull: directed and random plane loads and box tests,
// each result checked against an in-order prediction of the culling verdict.
// Depends on afc_pkg and the aabb_frustum_cull RTL.
module tb_aabb_frustum_cull
  import afc_pkg::*;
();

  localparam int PLANES      = PLANE_COUNT_DEF;
  localparam int FRAC        = FRAC_BITS_DEF;
  localparam int LATENCY     = 2 * PLANES + 1;
  localparam int STALL_LIMIT = 2000;
  localparam int RAND_ITEMS  = 1200;
  localparam int PHASES      = 6;

  typedef struct {
    action_t            action;
    logic [SLOT_W-1:0]  slot;
    logic [COORD_W-1:0] nx;
    logic [COORD_W-1:0] ny;
    logic [COORD_W-1:0] nz;
    logic [COORD_W-1:0] offset;
    logic [COORD_W-1:0] min_x;
    logic [COORD_W-1:0] min_y;
    logic [COORD_W-1:0] min_z;
    logic [COORD_W-1:0] max_x;
    logic [COORD_W-1:0] max_y;
    logic [COORD_W-1:0] max_z;
  } cull_item_t;

  typedef struct {
    logic              visible;
    logic [CODE_W-1:0] reject_plane;
  } cull_verdict_t;

  // Plane store mirror plus the queue of verdicts still owed by the block
  class cull_scoreboard;
    logic [COORD_W-1:0] plane_nx[PLANES];
    logic [COORD_W-1:0] plane_ny[PLANES];
    logic [COORD_W-1:0] plane_nz[PLANES];
    logic [COORD_W-1:0] plane_d[PLANES];
    cull_verdict_t      verdict_q[$];
    int unsigned        fail_count;

    function new();
      foreach (plane_nx[i]) begin
        plane_nx[i] = '0;
        plane_ny[i] = '0;
        plane_nz[i] = '0;
        plane_d[i]  = '0;
      end
      fail_count = 0;
    endfunction

    // sign of n.p + d*2^FRAC, evaluated exactly at full width
    function bit outside_plane(int idx, logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
                               logic [COORD_W-1:0] pz);
      logic signed [SUM_W-1:0] acc;
      logic signed [SUM_W-1:0] n_w;
      logic signed [SUM_W-1:0] p_w;
      acc = $signed(plane_d[idx]);
      acc = acc <<< FRAC;
      n_w = $signed(plane_nx[idx]);
      p_w = $signed(px);
      acc = acc + n_w * p_w;
      n_w = $signed(plane_ny[idx]);
      p_w = $signed(py);
      acc = acc + n_w * p_w;
      n_w = $signed(plane_nz[idx]);
      p_w = $signed(pz);
      acc = acc + n_w * p_w;
      return acc[SUM_W-1];
    endfunction

    // called once per accepted input transfer
    function void note_item(cull_item_t it);
      cull_verdict_t      v;
      logic [COORD_W-1:0] px;
      logic [COORD_W-1:0] py;
      logic [COORD_W-1:0] pz;
      bit                 found;
      v.visible      = 1'b0;
      v.reject_plane = CODE_W'(PLANES);
      if (it.action == ACT_LOAD) begin
        // slots past the last plane are dropped
        if (it.slot < PLANES) begin
          plane_nx[it.slot] = it.nx;
          plane_ny[it.slot] = it.ny;
          plane_nz[it.slot] = it.nz;
          plane_d[it.slot]  = it.offset;
        end
      end else begin
        found = 1'b0;
        for (int i = 0; i < PLANES; i++) begin
          if (!found) begin
            // positive vertex: max corner where the normal is non-negative
            px = plane_nx[i][COORD_W-1] ? it.min_x : it.max_x;
            py = plane_ny[i][COORD_W-1] ? it.min_y : it.max_y;
            pz = plane_nz[i][COORD_W-1] ? it.min_z : it.max_z;
            if (outside_plane(i, px, py, pz)) begin
              found          = 1'b1;
              v.reject_plane = CODE_W'(i);
            end
          end
        end
        v.visible = !found;
      end
      verdict_q.push_back(v);
    endfunction

    // called once per result strobe
    function void check_result(logic visible, logic [CODE_W-1:0] reject_plane);
      cull_verdict_t want;
      if (verdict_q.size() == 0) begin
        $error("result with nothing pending: visible=%0d reject_plane=%0d",
               visible, reject_plane);
        fail_count++;
        return;
      end
      want = verdict_q.pop_front();
      if (visible !== want.visible) begin
        $error("visible: expected %0d, actual %0d", want.visible, visible);
        fail_count++;
      end
      if (reject_plane !== want.reject_plane) begin
        $error("reject_plane: expected %0d, actual %0d", want.reject_plane, reject_plane);
        fail_count++;
      end
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [0:0]         in_action;
  logic [SLOT_W-1:0]  in_plane_slot;
  logic [COORD_W-1:0] in_normal_x;
  logic [COORD_W-1:0] in_normal_y;
  logic [COORD_W-1:0] in_normal_z;
  logic [COORD_W-1:0] in_plane_offset;
  logic [COORD_W-1:0] in_min_x;
  logic [COORD_W-1:0] in_min_y;
  logic [COORD_W-1:0] in_min_z;
  logic [COORD_W-1:0] in_max_x;
  logic [COORD_W-1:0] in_max_y;
  logic [COORD_W-1:0] in_max_z;
  logic               out_valid;
  logic               out_visible;
  logic [CODE_W-1:0]  out_reject_plane;

  cull_scoreboard sb;
  int unsigned    idle_cycles = 0;

  aabb_frustum_cull #(
    .PLANE_COUNT (PLANES),
    .FRAC_BITS   (FRAC)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_plane_slot    (in_plane_slot),
    .in_normal_x      (in_normal_x),
    .in_normal_y      (in_normal_y),
    .in_normal_z      (in_normal_z),
    .in_plane_offset  (in_plane_offset),
    .in_min_x         (in_min_x),
    .in_min_y         (in_min_y),
    .in_min_z         (in_min_z),
    .in_max_x         (in_max_x),
    .in_max_y         (in_max_y),
    .in_max_z         (in_max_z),
    .out_valid        (out_valid),
    .out_visible      (out_visible),
    .out_reject_plane (out_reject_plane)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Result check and stall watchdog
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      sb.check_result(out_visible, out_reject_plane);
    end
    if ((start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("** aabb_frustum_cull: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Mix of full-range, extreme and small Q16.16 values
  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0, 1: return $urandom();
      2: begin
        case ($urandom_range(0, 4))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return 32'h0000_0000;
          3:       return 32'hFFFF_FFFF;
          default: return 32'h0001_0000;
        endcase
      end
      default: return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
    endcase
  endfunction

  // Offsets lean positive so boxes get past the early planes
  function automatic logic [COORD_W-1:0] rand_offset();
    case ($urandom_range(0, 7))
      0, 1:    return $urandom();
      2:       return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      3, 4:    return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
      default: return 32'($urandom_range(32'h1000_0000, 32'h7FFF_FFFF));
    endcase
  endfunction

  function automatic cull_item_t rand_item(int load_pct);
    cull_item_t         it;
    logic [COORD_W-1:0] tmp;
    it.action = ($urandom_range(0, 99) < load_pct) ? ACT_LOAD : ACT_BOX;
    it.slot   = SLOT_W'($urandom_range(0, 7));
    it.nx     = rand_coord();
    it.ny     = rand_coord();
    it.nz     = rand_coord();
    it.offset = rand_offset();
    it.min_x  = rand_coord();
    it.min_y  = rand_coord();
    it.min_z  = rand_coord();
    it.max_x  = rand_coord();
    it.max_y  = rand_coord();
    it.max_z  = rand_coord();
    // most boxes well ordered, the rest left inverted on some axes
    if ($urandom_range(0, 3) != 0) begin
      if ($signed(it.min_x) > $signed(it.max_x)) begin
        tmp = it.min_x; it.min_x = it.max_x; it.max_x = tmp;
      end
      if ($signed(it.min_y) > $signed(it.max_y)) begin
        tmp = it.min_y; it.min_y = it.max_y; it.max_y = tmp;
      end
      if ($signed(it.min_z) > $signed(it.max_z)) begin
        tmp = it.min_z; it.min_z = it.max_z; it.max_z = tmp;
      end
    end
    return it;
  endfunction

  function automatic cull_item_t plane_load(int slot, logic [COORD_W-1:0] nx,
                                            logic [COORD_W-1:0] ny, logic [COORD_W-1:0] nz,
                                            logic [COORD_W-1:0] d);
    cull_item_t it;
    it        = rand_item(0);
    it.action = ACT_LOAD;
    it.slot   = SLOT_W'(slot);
    it.nx     = nx;
    it.ny     = ny;
    it.nz     = nz;
    it.offset = d;
    return it;
  endfunction

  function automatic cull_item_t box_test(logic [COORD_W-1:0] lo, logic [COORD_W-1:0] hi);
    cull_item_t it;
    it        = rand_item(0);
    it.action = ACT_BOX;
    it.min_x  = lo;
    it.min_y  = lo;
    it.min_z  = lo;
    it.max_x  = hi;
    it.max_y  = hi;
    it.max_z  = hi;
    return it;
  endfunction

  // Present one item after gap idle cycles and hold it until the transfer
  task automatic send_item(input cull_item_t it, input int gap);
    repeat (gap) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    start           = 1'b1;
    in_action       = it.action;
    in_plane_slot   = it.slot;
    in_normal_x     = it.nx;
    in_normal_y     = it.ny;
    in_normal_z     = it.nz;
    in_plane_offset = it.offset;
    in_min_x        = it.min_x;
    in_min_y        = it.min_y;
    in_min_z        = it.min_z;
    in_max_x        = it.max_x;
    in_max_y        = it.max_y;
    in_max_z        = it.max_z;
    do @(posedge clk); while (busy);
    sb.note_item(it);
  endtask

  // Stop sending and wait for every pending result
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int gap;
    int load_pct;
    bit burst;
    sb              = new();
    rst_n           = 1'b0;
    start           = 1'b0;
    in_action       = '0;
    in_plane_slot   = '0;
    in_normal_x     = '0;
    in_normal_y     = '0;
    in_normal_z     = '0;
    in_plane_offset = '0;
    in_min_x        = '0;
    in_min_y        = '0;
    in_min_z        = '0;
    in_max_x        = '0;
    in_max_y        = '0;
    in_max_z        = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: all-zero planes never reject, even for extreme corners
    send_item(box_test(32'h0000_0000, 32'h0000_0000), 0);
    send_item(box_test(32'h8000_0000, 32'h7FFF_FFFF), 0);
    // loads to slots past the last plane must leave the store alone
    send_item(plane_load(6, '0, '0, '0, 32'hFFFF_FFFF), 0);
    send_item(plane_load(7, '0, '0, '0, 32'h8000_0000), 1);
    send_item(box_test(32'h0000_0000, 32'h0000_0000), 0);
    // extreme normal and offset, normal and inverted boxes
    send_item(plane_load(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000), 0);
    send_item(box_test(32'h8000_0000, 32'h7FFF_FFFF), 0);
    send_item(box_test(32'h0000_0000, 32'h0000_0000), 2);
    send_item(box_test(32'h7FFF_FFFF, 32'h8000_0000), 0);
    // walk the rejecting plane from the last slot down to the first
    send_item(plane_load(0, '0, '0, '0, '0), 0);
    for (int k = PLANES - 1; k >= 0; k--) begin
      send_item(plane_load(k, '0, '0, '0, 32'hFFFF_FFFF), 0);
      send_item(box_test(32'h0000_0000, 32'h0000_0000), 0);
    end
    send_item(plane_load(0, '0, '0, '0, 32'h7FFF_FFFF), 0);
    send_item(box_test(32'h8000_0000, 32'h7FFF_FFFF), 0);
    drain();

    // Random phases: different load mixes, back-to-back or gapped traffic
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       load_pct = 10;
        1:       load_pct = 25;
        2:       load_pct = 40;
        3:       load_pct = 5;
        4:       load_pct = 20;
        default: load_pct = 15;
      endcase
      burst = (ph % 3 == 0);
      for (int n = 0; n < RAND_ITEMS / PHASES; n++) begin
        if (burst || $urandom_range(0, 3) == 0) gap = 0;
        else gap = $urandom_range(0, 10);
        send_item(rand_item(load_pct), gap);
      end
      drain();
    end

    // let any stray strobe surface before the verdict
    repeat (LATENCY + 8) @(posedge clk);
    if (sb.fail_count == 0) begin
      $display("** aabb_frustum_cull: PASSED **");
    end else begin
      $display("** aabb_frustum_cull: FAILED **");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/afc_pkg.sv
hdl/afc_cell.sv
hdl/aabb_frustum_cull.sv
hdl/afc_checker.sv
verif/tb_aabb_frustum_cull.sv
